/* src/assert_macros.svh */
// Assertion helpers; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SCC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("scc assertion failed");

`define SCC_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("scc forbidden condition");

`else

`define SCC_ASSERT(lbl, clk, rst_n, prop)

`define SCC_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

/* src/scc_pkg.sv */
package scc_pkg;

	localparam int MAX_LINE_DEF = 4096;
	localparam int DEPTH_W = 14;
	localparam int KEEP_W = 13;
	localparam int SHEBANG_MIN = 3;

	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_BANG = 8'h21;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;

	localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};
	localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};

	typedef enum logic [1:0] {
		ACT_KEEP   = 2'd0,
		ACT_PREFIX = 2'd1,
		ACT_DROP   = 2'd2
	} action_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       line_end;
	} in_word_t;

	typedef struct packed {
		action_t             line_action;
		logic [KEEP_W-1:0]   keep_length;
	} out_word_t;

	function automatic logic is_ws(input logic [7:0] b);
		return b inside {8'h20, [8'h09:8'h0D]};
	endfunction

	function automatic logic signed [DEPTH_W-1:0] depth_step(
		input logic signed [DEPTH_W-1:0] d,
		input logic up
	);
		logic signed [DEPTH_W-1:0] r;
		r = d;
		if (up) begin
			if (d != DEPTH_MAX) r = d + DEPTH_W'(1);
		end else begin
			if (d != DEPTH_MIN) r = d - DEPTH_W'(1);
		end
		return r;
	endfunction

endpackage

/* src/scc_scan.sv */
`include "assert_macros.svh"

module scc_scan import scc_pkg::*; #(
	parameter int MAX_LINE = MAX_LINE_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  in_word_t  word,
	output out_word_t verdict
);

	localparam int POS_W = $clog2(MAX_LINE + 1);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LINE);
	localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);

	logic                      first_q, shebang_q, cut_q, sq_q, dq_q;
	logic [POS_W-1:0]          pos_q, kept_q;
	logic signed [DEPTH_W-1:0] brace_q, paren_q;
	logic [7:0]                prev_q;

	logic                      shebang_d, cut_d, sq_d, dq_d, opens;
	logic [POS_W-1:0]          pos_d, kept_d;
	logic signed [DEPTH_W-1:0] brace_d, paren_d;
	logic [7:0]                b;

	assign b = word.text_byte;

	always_comb begin
		shebang_d = shebang_q;
		cut_d = cut_q;
		sq_d = sq_q;
		dq_d = dq_q;
		brace_d = brace_q;
		paren_d = paren_q;
		kept_d = kept_q;
		opens = 1'b0;
		if (!cut_q) begin
			if (b == CH_HASH) begin
				opens = (pos_q == '0) ||
					(!sq_q && !dq_q && (brace_q <= 0) && (paren_q <= 0) &&
					 prev_q != CH_DOLLAR && prev_q != CH_BSLASH);
			end
			if (opens) begin
				cut_d = 1'b1;
				if (pos_q == '0 && first_q) shebang_d = 1'b1;
			end else begin
				case (b)
					CH_SQUOTE: sq_d = !sq_q;
					CH_DQUOTE: dq_d = !dq_q;
					CH_LBRACE: brace_d = depth_step(brace_q, 1'b1);
					CH_RBRACE: brace_d = depth_step(brace_q, 1'b0);
					CH_LPAREN: paren_d = depth_step(paren_q, 1'b1);
					CH_RPAREN: paren_d = depth_step(paren_q, 1'b0);
					default: ;
				endcase
				if (!is_ws(b)) kept_d = (pos_q < POS_MAX) ? pos_q + POS_ONE : POS_MAX;
			end
		end
		if (first_q && pos_q == POS_ONE && b != CH_BANG) shebang_d = 1'b0;
		pos_d = (pos_q < POS_MAX) ? pos_q + POS_ONE : pos_q;
	end

	always_comb begin
		verdict.line_action = ACT_KEEP;
		verdict.keep_length = '0;
		if (first_q && shebang_d && pos_d > POS_W'(SHEBANG_MIN)) begin
			verdict.line_action = ACT_KEEP;
		end else if (!cut_d) begin
			verdict.line_action = ACT_KEEP;
		end else if (kept_d == '0) begin
			verdict.line_action = ACT_DROP;
		end else begin
			verdict.line_action = ACT_PREFIX;
			verdict.keep_length = KEEP_W'(kept_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			shebang_q <= 1'b0;
			cut_q <= 1'b0;
			sq_q <= 1'b0;
			dq_q <= 1'b0;
			pos_q <= '0;
			kept_q <= '0;
			brace_q <= '0;
			paren_q <= '0;
			prev_q <= '0;
		end else if (en) begin
			if (word.line_end) begin
				first_q <= 1'b0;
				shebang_q <= 1'b0;
				cut_q <= 1'b0;
				sq_q <= 1'b0;
				dq_q <= 1'b0;
				pos_q <= '0;
				kept_q <= '0;
				brace_q <= '0;
				paren_q <= '0;
				prev_q <= '0;
			end else begin
				shebang_q <= shebang_d;
				cut_q <= cut_d;
				sq_q <= sq_d;
				dq_q <= dq_d;
				pos_q <= pos_d;
				kept_q <= kept_d;
				brace_q <= brace_d;
				paren_q <= paren_d;
				prev_q <= b;
			end
		end
	end

	`SCC_ASSERT(a_line_clears, clk, arst_n, (en && word.line_end) |=> (pos_q == '0 && !cut_q))
	`SCC_NEVER(a_kept_in_line, clk, arst_n, kept_q > pos_q)
	`SCC_ASSERT(a_first_ends, clk, arst_n, $fell(first_q) |-> $past(en && word.line_end))
	`SCC_ASSERT(a_idle_holds, clk, arst_n, !en |=> $stable(pos_q))

endmodule

/* src/shell_comment_cut_finder.sv */
// A byte accepted at the input is registered into word_s1 and scanned from there; the verdict
// for a line is registered into verdict_q when the line's last byte advances from word_s1.
// Throughput: one byte per cycle unless the input stalls; the scanner updates once per byte.
// Input stalls only when a line's last byte waits for a stalled output register.
// Reset (arst_n low, asynchronous): pipeline empty, scanner state cleared, first line armed.
`include "assert_macros.svh"

module shell_comment_cut_finder import scc_pkg::*; #(
	parameter int MAX_LINE = MAX_LINE_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	output logic      byte_stall,
	input  in_word_t  byte_word,
	output logic      verdict_valid,
	input  logic      verdict_stall,
	output out_word_t verdict_word
);

	logic      valid_s1;
	in_word_t  word_s1;
	logic      adv;
	out_word_t verdict;
	logic      verdict_valid_q;
	out_word_t verdict_q;

	assign adv = valid_s1 && (!word_s1.line_end || !verdict_valid_q || !verdict_stall);
	assign byte_stall = valid_s1 && !adv;

	scc_scan #(
		.MAX_LINE(MAX_LINE)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.word   (word_s1),
		.verdict(verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			verdict_valid_q <= 1'b0;
		end else begin
			if (!byte_stall) valid_s1 <= byte_valid;
			if (adv && word_s1.line_end) verdict_valid_q <= 1'b1;
			else if (!verdict_stall) verdict_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) word_s1 <= byte_word;
		if (adv && word_s1.line_end) verdict_q <= verdict;
	end

	assign verdict_valid = verdict_valid_q;
	assign verdict_word = verdict_q;

	`SCC_ASSERT(a_verdict_src, clk, arst_n, $rose(verdict_valid_q) |-> $past(valid_s1 && word_s1.line_end))
	`SCC_NEVER(a_no_overwrite, clk, arst_n, adv && word_s1.line_end && verdict_valid_q && verdict_stall)

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
	import scc_pkg::*;

	localparam int LINE_CAP = MAX_LINE_DEF;
	localparam int RANDOM_BYTES = 730;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      byte_valid = 1'b0;
	logic      byte_stall;
	in_word_t  byte_word = '0;
	logic      verdict_valid;
	logic      verdict_stall = 1'b0;
	out_word_t verdict_word;

	in_word_t  pending_bytes[$];
	out_word_t verdicts_due[$];
	int        total_lines = 0;
	int        lines_sent = 0;
	int        errors = 0;

	// scanner model state
	bit                        on_first;
	bit                        shebang;
	bit                        cut_found;
	bit                        in_sq;
	bit                        in_dq;
	int                        cur_pos;
	int                        kept_end;
	logic signed [DEPTH_W-1:0] braces;
	logic signed [DEPTH_W-1:0] parens;
	logic [7:0]                prev_byte;

	shell_comment_cut_finder DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_word    (byte_word),
		.verdict_valid(verdict_valid),
		.verdict_stall(verdict_stall),
		.verdict_word (verdict_word)
	);

	always #2 clk = ~clk;

	function automatic bit blank_byte(input logic [7:0] b);
		return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	function automatic logic signed [DEPTH_W-1:0] nest(input logic signed [DEPTH_W-1:0] d,
			input bit up);
		int n;
		n = int'(d) + (up ? 1 : -1);
		if (n > int'(DEPTH_MAX)) n = int'(DEPTH_MAX);
		if (n < int'(DEPTH_MIN)) n = int'(DEPTH_MIN);
		return DEPTH_W'(n);
	endfunction

	task automatic clear_line();
		shebang = 1'b0;
		cut_found = 1'b0;
		in_sq = 1'b0;
		in_dq = 1'b0;
		cur_pos = 0;
		kept_end = 0;
		braces = '0;
		parens = '0;
		prev_byte = '0;
	endtask

	task automatic scan_byte(input in_word_t w);
		logic [7:0] b;
		int         at;
		bit         opens;
		out_word_t  v;
		b = w.text_byte;
		at = cur_pos;
		opens = 1'b0;
		if (!cut_found) begin
			if (b == CH_HASH) begin
				if (at == 0)
					opens = 1'b1;
				else if (!in_sq && !in_dq && braces <= 0 && parens <= 0 &&
						prev_byte != CH_DOLLAR && prev_byte != CH_BSLASH)
					opens = 1'b1;
			end
			if (opens) begin
				cut_found = 1'b1;
				if (at == 0 && on_first) shebang = 1'b1;
			end else begin
				case (b)
					CH_SQUOTE: in_sq = !in_sq;
					CH_DQUOTE: in_dq = !in_dq;
					CH_LBRACE: braces = nest(braces, 1'b1);
					CH_RBRACE: braces = nest(braces, 1'b0);
					CH_LPAREN: parens = nest(parens, 1'b1);
					CH_RPAREN: parens = nest(parens, 1'b0);
					default: ;
				endcase
				if (!blank_byte(b)) kept_end = (at + 1 < LINE_CAP) ? at + 1 : LINE_CAP;
			end
		end
		if (on_first && at == 1 && b != CH_BANG) shebang = 1'b0;
		prev_byte = b;
		if (cur_pos < LINE_CAP) cur_pos++;
		if (w.line_end) begin
			v.keep_length = '0;
			if (on_first && shebang && cur_pos > SHEBANG_MIN) begin
				v.line_action = ACT_KEEP;
			end else if (!cut_found) begin
				v.line_action = ACT_KEEP;
			end else if (kept_end == 0) begin
				v.line_action = ACT_DROP;
			end else begin
				v.line_action = ACT_PREFIX;
				v.keep_length = KEEP_W'(kept_end);
			end
			verdicts_due.push_back(v);
			clear_line();
			on_first = 1'b0;
		end
	endtask

	task automatic put(input logic [7:0] b);
		in_word_t w;
		w.text_byte = b;
		w.line_end = 1'b0;
		pending_bytes.push_back(w);
	endtask

	task automatic end_line(input logic [7:0] b);
		in_word_t w;
		w.text_byte = b;
		w.line_end = 1'b1;
		pending_bytes.push_back(w);
		total_lines++;
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++) put(s[i]);
	endtask

	task automatic put_line(input string s);
		put_text(s.substr(0, s.len() - 2));
		end_line(s[s.len() - 1]);
	endtask

	task automatic put_quoted(input logic [7:0] q);
		int n;
		n = $urandom_range(0, 5);
		put(q);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 3))
				0: put(CH_HASH);
				1: put(8'h20);
				default: put(8'($urandom_range(97, 122)));
			endcase
		end
		put(q);
	endtask

	task automatic random_line();
		int            chunks;
		int            n;
		logic [7:0]    odd_chars[16];
		odd_chars = '{CH_HASH, CH_DOLLAR, CH_BSLASH, CH_BANG, CH_SQUOTE, CH_DQUOTE,
			CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, 8'h20, 8'h09, 8'h0B, 8'h0C,
			8'h0D, 8'h0A};
		chunks = $urandom_range(1, 6);
		for (int c = 0; c < chunks; c++) begin
			case ($urandom_range(0, 11))
				0: begin
					n = $urandom_range(1, 5);
					for (int i = 0; i < n; i++) put(8'($urandom_range(97, 122)));
				end
				1: put($urandom_range(0, 1) ? 8'h20 : 8'h09);
				2: put_quoted(CH_DQUOTE);
				3: put_quoted(CH_SQUOTE);
				4: put_text($urandom_range(0, 1) ? "${x}" : "${#x}");
				5: put_text("$(ls)");
				6: put_text("$#");
				7: put_text("\\#");
				8: begin
					put_text(" # ");
					n = $urandom_range(0, 4);
					for (int i = 0; i < n; i++) put(8'($urandom_range(0, 255)));
				end
				9: put(8'($urandom_range(0, 255)));
				10: put(odd_chars[$urandom_range(0, 15)]);
				default: put(CH_HASH);
			endcase
		end
		if ($urandom_range(0, 9) < 7)
			end_line(8'h0A);
		else
			end_line(8'($urandom_range(0, 255)));
	endtask

	task automatic fill_stimulus();
		int start;
		// only one first line per run: pick its shape
		case ($urandom_range(0, 6))
			0: put_line("#!/bin/sh\n");
			1: put_line("#!\n");
			2: put_line("#!x\n");
			3: put_line("#x!\n");
			4: put_line("echo # c\n");
			5: begin put(CH_HASH); end_line(CH_BANG); end
			default: put_line("a!#\n");
		endcase
		put_line("#!/bin/sh\n");
		put_line("echo hi # c\n");
		put_line("   # only\n");
		put_line("x='#'\n");
		put_line("y=\"#\"\n");
		put_line("a=\"it's\" # c\n");
		put_line("${#x} z\n");
		put_line("$(#)\n");
		put_line("echo $# x\n");
		put_line("echo \\# x\n");
		put_line("}} # neg\n");
		put_line("a) # x\n");
		put_line("ab \t\v\f\r# x\n");
		put_text("a"); put(8'h80); put_line(" # x\n");
		put(8'h00); end_line(CH_HASH);
		put(8'hFF); end_line(8'h00);
		end_line(CH_HASH);
		end_line(8'h0A);
		put_line("# a ' b\n");
		put_line("a #b ' { ( \"\n");
		put_text("tail"); end_line(8'h78);
		start = pending_bytes.size();
		while (pending_bytes.size() - start < RANDOM_BYTES) random_line();
	endtask

	function automatic int send_idle_pct(input int sent);
		if (sent * 3 < total_lines) return 34;
		if (sent * 3 < total_lines * 2) return 81;
		return 0;
	endfunction

	function automatic int recv_idle_pct(input int sent);
		if (sent * 3 < total_lines) return 81;
		if (sent * 3 < total_lines * 2) return 34;
		return 0;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			byte_word <= '0;
			on_first = 1'b1;
			clear_line();
		end else begin
			if (byte_valid && !byte_stall) begin
				scan_byte(byte_word);
				if (byte_word.line_end) lines_sent++;
			end
			if (!byte_valid || !byte_stall) begin
				if (pending_bytes.size() != 0 &&
						$urandom_range(0, 99) >= send_idle_pct(lines_sent)) begin
					byte_word <= pending_bytes.pop_front();
					byte_valid <= 1'b1;
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			verdict_stall <= 1'b0;
		end else begin
			if (verdict_valid && !verdict_stall) begin
				if (verdicts_due.size() == 0) begin
					$display("%0t: verdict with nothing expected: action %0d keep %0d",
						$time, verdict_word.line_action, verdict_word.keep_length);
					errors++;
				end else begin
					want = verdicts_due.pop_front();
					if (verdict_word.line_action !== want.line_action ||
							verdict_word.keep_length !== want.keep_length) begin
						$display("%0t: expected action %0d keep %0d, got action %0d keep %0d",
							$time, want.line_action, want.keep_length,
							verdict_word.line_action, verdict_word.keep_length);
						errors++;
					end
				end
			end
			verdict_stall <= ($urandom_range(0, 99) < recv_idle_pct(lines_sent));
		end
	end

	initial begin
		fill_stimulus();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (pending_bytes.size() != 0 || byte_valid) @(posedge clk);
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("tb: PASS");
		end else begin
			$display("%0t: %0d verdicts left over", $time, verdicts_due.size());
			$display("tb: FAIL");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("%0t: timeout", $time);
		$display("tb: FAIL");
		$finish;
	end

endmodule

/* files.f */
+incdir+src
src/scc_pkg.sv
src/scc_scan.sv
src/shell_comment_cut_finder.sv
tb/tb.sv
